### rtl/lli_pkg.sv
`timescale 1ns / 1ps

package lli_pkg;

	localparam int OUT_WIDTH = 48;

	// sign and flag bits that ride along the divider row
	typedef struct packed {
		logic par;
		logic neg_x;
		logic neg_y;
	} lli_flags_t;

endpackage

### rtl/lli_div_cell.sv
`timescale 1ns / 1ps

module lli_div_cell import lli_pkg::*; #(
	parameter int DW = 43,
	parameter int NB = 80
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [DW-1:0]   in_rem_x,
	input  logic [NB-1:0]   in_dq_x,
	input  logic [DW-1:0]   in_rem_y,
	input  logic [NB-1:0]   in_dq_y,
	input  logic [DW-1:0]   in_den,
	input  lli_flags_t      in_flags,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [DW-1:0]   out_rem_x,
	output logic [NB-1:0]   out_dq_x,
	output logic [DW-1:0]   out_rem_y,
	output logic [NB-1:0]   out_dq_y,
	output logic [DW-1:0]   out_den,
	output lli_flags_t      out_flags
);

	logic [DW:0] tx, ty, dx, dy;
	logic        gx, gy;

	assign in_ready = !out_valid || out_ready;

	// one restoring step: bring in the next dividend bit, subtract if it fits
	always_comb begin
		tx = {in_rem_x, in_dq_x[NB-1]};
		ty = {in_rem_y, in_dq_y[NB-1]};
		dx = tx - {1'b0, in_den};
		dy = ty - {1'b0, in_den};
		gx = tx >= {1'b0, in_den};
		gy = ty >= {1'b0, in_den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_rem_x <= gx ? dx[DW-1:0] : tx[DW-1:0];
			out_rem_y <= gy ? dy[DW-1:0] : ty[DW-1:0];
			out_dq_x  <= {in_dq_x[NB-2:0], gx};
			out_dq_y  <= {in_dq_y[NB-2:0], gy};
			out_den   <= in_den;
			out_flags <= in_flags;
		end
	end

endmodule

### rtl/line_line_intersection_top.sv
`timescale 1ns / 1ps

// channel  dir  handshake         payload
// s_*      in   tvalid / tready   tdata: 8 coordinates, COORD_WIDTH bits each
// m_*      out  tvalid / tready   tdata: cross_x, cross_y; tuser: parallel, saturated
//
// one word per cycle while the output is not stalled; the row of divider cells
// computes one quotient bit per cell
// reset clears only the valid bits of the stages
// each stage takes a word when it is empty or its successor moves, so bubbles fill
// while the output is stalled

module line_line_intersection_top import lli_pkg::*; #(
	parameter int COORD_WIDTH = 20,
	parameter int FRAC_BITS   = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// line1_start_x, line1_start_y, line1_end_x, line1_end_y,
	// line2_start_x, line2_start_y, line2_end_x, line2_end_y, zero fill
	input  logic [((8*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// cross_x, cross_y
	output logic [2*OUT_WIDTH-1:0]      m_tdata,
	// parallel, saturated
	output logic [1:0]                  m_tuser
);

	localparam int W  = COORD_WIDTH;
	localparam int AW = W + 1;
	localparam int PW = 2 * W + 1;
	localparam int DP = 2 * W + 2;
	localparam int CW = 2 * W + 2;
	localparam int DW = 2 * W + 3;
	localparam int MW = 3 * W + 3;
	localparam int NW = 3 * W + 4;
	localparam int NB = NW + FRAC_BITS;
	localparam int QW = (NB > OUT_WIDTH) ? NB : OUT_WIDTH;

	logic signed [W-1:0] f [8];

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			f[k] = s_tdata[k*W +: W];
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_o;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_o;
	logic cell_rdy [NB+1];

	assign rdy_o    = !v_o || m_tready;
	assign rdy6     = !v_s6 || cell_rdy[0];
	assign rdy5     = !v_s5 || rdy6;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;
	assign cell_rdy[NB] = rdy_o;

	// line coefficients a and b
	logic signed [AW-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [W-1:0]  sx1_s1, sy1_s1, sx2_s1, sy2_s1;
	// products for c and the determinant
	logic signed [AW-1:0] a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [PW-1:0] m1_s2, m2_s2, m3_s2, m4_s2;
	logic signed [DP-1:0] d1_s2, d2_s2;
	logic signed [AW-1:0] a1_s3, b1_s3, a2_s3, b2_s3;
	logic signed [CW-1:0] c1_s3, c2_s3;
	logic signed [DW-1:0] det_s3, det_s4, det_s5;
	logic signed [MW-1:0] px1_s4, px2_s4, py1_s4, py2_s4;
	logic signed [NW-1:0] nx_s5, ny_s5;
	logic [NB-1:0]        dqx_s6, dqy_s6;
	logic [DW-1:0]        den_s6;
	lli_flags_t           flg_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			a1_s1  <= AW'(f[1]) - AW'(f[3]);
			b1_s1  <= AW'(f[2]) - AW'(f[0]);
			a2_s1  <= AW'(f[5]) - AW'(f[7]);
			b2_s1  <= AW'(f[6]) - AW'(f[4]);
			sx1_s1 <= f[0];
			sy1_s1 <= f[1];
			sx2_s1 <= f[4];
			sy2_s1 <= f[5];
		end
		if (rdy2 && v_s1) begin
			m1_s2 <= a1_s1 * sx1_s1;
			m2_s2 <= b1_s1 * sy1_s1;
			m3_s2 <= a2_s1 * sx2_s1;
			m4_s2 <= b2_s1 * sy2_s1;
			d1_s2 <= a1_s1 * b2_s1;
			d2_s2 <= a2_s1 * b1_s1;
			a1_s2 <= a1_s1;
			b1_s2 <= b1_s1;
			a2_s2 <= a2_s1;
			b2_s2 <= b2_s1;
		end
		if (rdy3 && v_s2) begin
			c1_s3  <= -CW'(m1_s2) - CW'(m2_s2);
			c2_s3  <= -CW'(m3_s2) - CW'(m4_s2);
			det_s3 <= DW'(d1_s2) - DW'(d2_s2);
			a1_s3  <= a1_s2;
			b1_s3  <= b1_s2;
			a2_s3  <= a2_s2;
			b2_s3  <= b2_s2;
		end
		if (rdy4 && v_s3) begin
			px1_s4 <= b1_s3 * c2_s3;
			px2_s4 <= b2_s3 * c1_s3;
			py1_s4 <= a2_s3 * c1_s3;
			py2_s4 <= a1_s3 * c2_s3;
			det_s4 <= det_s3;
		end
		if (rdy5 && v_s4) begin
			nx_s5  <= NW'(px1_s4) - NW'(px2_s4);
			ny_s5  <= NW'(py1_s4) - NW'(py2_s4);
			det_s5 <= det_s4;
		end
		if (rdy6 && v_s5) begin
			// magnitudes into the divider, numerator scaled by the fraction bits
			dqx_s6 <= NB'(nx_s5[NW-1] ? -nx_s5 : nx_s5) << FRAC_BITS;
			dqy_s6 <= NB'(ny_s5[NW-1] ? -ny_s5 : ny_s5) << FRAC_BITS;
			den_s6 <= det_s5[DW-1] ? -det_s5 : det_s5;
			flg_s6.par   <= det_s5 == '0;
			flg_s6.neg_x <= nx_s5[NW-1] ^ det_s5[DW-1];
			flg_s6.neg_y <= ny_s5[NW-1] ^ det_s5[DW-1];
		end
	end

	logic             cv   [NB+1];
	logic [DW-1:0]    crx  [NB+1];
	logic [DW-1:0]    cry  [NB+1];
	logic [NB-1:0]    cqx  [NB+1];
	logic [NB-1:0]    cqy  [NB+1];
	logic [DW-1:0]    cden [NB+1];
	lli_flags_t       cflg [NB+1];

	assign cv[0]   = v_s6;
	assign crx[0]  = '0;
	assign cry[0]  = '0;
	assign cqx[0]  = dqx_s6;
	assign cqy[0]  = dqy_s6;
	assign cden[0] = den_s6;
	assign cflg[0] = flg_s6;

	for (genvar i = 0; i < NB; i++) begin : g_cell
		lli_div_cell #(
			.DW (DW),
			.NB (NB)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[i]),
			.in_ready  (cell_rdy[i]),
			.in_rem_x  (crx[i]),
			.in_dq_x   (cqx[i]),
			.in_rem_y  (cry[i]),
			.in_dq_y   (cqy[i]),
			.in_den    (cden[i]),
			.in_flags  (cflg[i]),
			.out_valid (cv[i+1]),
			.out_ready (cell_rdy[i+1]),
			.out_rem_x (crx[i+1]),
			.out_dq_x  (cqx[i+1]),
			.out_rem_y (cry[i+1]),
			.out_dq_y  (cqy[i+1]),
			.out_den   (cden[i+1]),
			.out_flags (cflg[i+1])
		);
	end

	logic [QW-1:0]        qx, qy, limx, limy;
	logic                 satx, saty;
	logic [OUT_WIDTH-1:0] mx, my, ox, oy;
	lli_flags_t           fo;

	// clamp the magnitude, then restore the sign
	always_comb begin
		fo   = cflg[NB];
		qx   = QW'(cqx[NB]);
		qy   = QW'(cqy[NB]);
		limx = (QW'(1) << (OUT_WIDTH - 1)) - QW'(!fo.neg_x);
		limy = (QW'(1) << (OUT_WIDTH - 1)) - QW'(!fo.neg_y);
		satx = qx > limx;
		saty = qy > limy;
		mx   = satx ? limx[OUT_WIDTH-1:0] : qx[OUT_WIDTH-1:0];
		my   = saty ? limy[OUT_WIDTH-1:0] : qy[OUT_WIDTH-1:0];
		ox   = fo.neg_x ? -mx : mx;
		oy   = fo.neg_y ? -my : my;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (rdy_o) begin
			v_o <= cv[NB];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && cv[NB]) begin
			if (fo.par) begin
				m_tdata <= '0;
				m_tuser <= 2'b01;
			end else begin
				m_tdata <= {oy, ox};
				m_tuser <= {satx || saty, 1'b0};
			end
		end
	end

	assign m_tvalid = v_o;

	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
		else $error("parallel word with nonzero payload");

	a_stall_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input blocked without an output stall");

	a_det_flag: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && flg_s6.par |-> den_s6 == '0)
		else $error("parallel flag with nonzero determinant");

endmodule

### sim/line_line_intersection_top_tb.sv
`timescale 1ns / 1ps

module line_line_intersection_top_tb import lli_pkg::*;;

	localparam int CW       = 20;
	localparam int FB       = 16;
	localparam int DW       = ((8*CW+7)/8)*8;
	localparam int N_RANDOM = 1130;
	localparam int LIMIT    = 600000;
	localparam int LATENCY  = 7 + 3*CW + 4 + FB;
	localparam int CMAX     = (1 << (CW-1)) - 1;
	localparam int CMIN     = -(1 << (CW-1));

	typedef struct {
		logic [OUT_WIDTH-1:0] cx;
		logic [OUT_WIDTH-1:0] cy;
		logic                 par;
		logic                 sat;
	} cross_t;

	typedef struct {
		logic [DW-1:0] word;
		bit            typed;
		cross_t        res;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DW-1:0]     s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [2*OUT_WIDTH-1:0] m_tdata;
	logic [1:0]        m_tuser;

	cross_t   pending_cross[$];
	dir_row_t dir_table[$];
	int       errors = 0;
	int       n_sent = 0;
	int       n_recv = 0;
	int       n_par = 0;
	int       n_sat = 0;
	int       cycles = 0;
	bit       stall_req = 1'b0;

	line_line_intersection_top #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycles,
				pending_cross.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic signed [127:0] coord(logic [DW-1:0] w, int k);
		logic signed [CW-1:0] v;
		v = w[k*CW +: CW];
		return v;
	endfunction

	function automatic logic [OUT_WIDTH-1:0] clamp_quot(logic signed [127:0] num,
			logic signed [127:0] det, inout logic sat);
		logic signed [127:0] q;
		logic signed [127:0] hi;
		logic signed [127:0] lo;
		hi = (128'sd1 <<< (OUT_WIDTH-1)) - 128'sd1;
		lo = -(128'sd1 <<< (OUT_WIDTH-1));
		q = (num <<< FB) / det;
		if (q > hi) begin
			q = hi;
			sat = 1'b1;
		end else if (q < lo) begin
			q = lo;
			sat = 1'b1;
		end
		return q[OUT_WIDTH-1:0];
	endfunction

	function automatic cross_t predict_cross(logic [DW-1:0] w);
		logic signed [127:0] a1, b1, c1, a2, b2, c2, det;
		cross_t r;
		a1 = coord(w, 1) - coord(w, 3);
		b1 = coord(w, 2) - coord(w, 0);
		c1 = -a1 * coord(w, 0) - b1 * coord(w, 1);
		a2 = coord(w, 5) - coord(w, 7);
		b2 = coord(w, 6) - coord(w, 4);
		c2 = -a2 * coord(w, 4) - b2 * coord(w, 5);
		det = a1 * b2 - a2 * b1;
		r.sat = 1'b0;
		if (det == 0) begin
			r.cx = '0;
			r.cy = '0;
			r.par = 1'b1;
		end else begin
			r.par = 1'b0;
			r.cx = clamp_quot(b1 * c2 - b2 * c1, det, r.sat);
			r.cy = clamp_quot(a2 * c1 - a1 * c2, det, r.sat);
		end
		return r;
	endfunction

	function automatic logic [DW-1:0] pack8(int c0, int c1, int c2, int c3,
			int c4, int c5, int c6, int c7);
		logic [DW-1:0] w;
		int c[8];
		c = '{c0, c1, c2, c3, c4, c5, c6, c7};
		w = '0;
		for (int k = 0; k < 8; k++)
			w[k*CW +: CW] = c[k][CW-1:0];
		return w;
	endfunction

	task automatic add_row(logic [DW-1:0] w, bit typed, longint cx = 0, longint cy = 0,
			bit par = 0, bit sat = 0);
		dir_row_t row;
		row.word = w;
		row.typed = typed;
		row.res.cx = cx[OUT_WIDTH-1:0];
		row.res.cy = cy[OUT_WIDTH-1:0];
		row.res.par = par;
		row.res.sat = sat;
		dir_table = {dir_table, row};
	endtask

	task automatic report_mismatch(string field, logic [OUT_WIDTH-1:0] got,
			logic [OUT_WIDTH-1:0] want);
		$display("mismatch on word %0d: %s got %h want %h", n_recv, field, got, want);
		errors++;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int rand_coord(int mode);
		int e[6];
		e = '{CMIN, CMAX, 0, -1, 1, CMIN + 1};
		case (mode)
			0: return $urandom_range(0, 15) - 8;
			1: return e[$urandom_range(0, 5)];
			default: return $urandom_range(0, (1 << CW) - 1) + CMIN;
		endcase
	endfunction

	function automatic logic [DW-1:0] random_word();
		int c[8];
		int kind;
		int dx, dy;
		kind = $urandom_range(0, 99);
		for (int k = 0; k < 8; k++)
			c[k] = rand_coord(kind < 10 ? 0 : (kind < 25 ? 1 : 2));
		if (kind >= 60 && kind < 75) begin
			// same direction on both lines, so the determinant is zero and the pair is parallel
			dx = $urandom_range(0, 200) - 100;
			dy = $urandom_range(0, 200) - 100;
			c[4] = c[0] + dx; c[5] = c[1] + dy;
			c[6] = c[2] + dx; c[7] = c[3] + dy;
		end else if (kind >= 75 && kind < 95) begin
			// nearly parallel, far apart ends can push the quotient out of range
			c[4] = c[0] + $urandom_range(0, 4) - 2; c[5] = c[1] + $urandom_range(0, 4) - 2;
			c[6] = c[2] + $urandom_range(0, 4) - 2; c[7] = c[3] + $urandom_range(0, 4) - 2;
		end else if (kind >= 95) begin
			// degenerate line, both points the same
			c[6] = c[4]; c[7] = c[5];
		end
		return pack8(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
	endfunction

	task automatic send_word(logic [DW-1:0] w, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		n_sent++;
	endtask

	// sender
	initial begin
		dir_row_t row;
		logic [DW-1:0] w;
		add_row(pack8(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 1, 0);
		add_row(pack8(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1, 0, 0, 1, 0);
		add_row(pack8(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1, 0, 0, 1, 0);
		add_row(pack8(0, 0, 1, 0, 0, 0, 0, 1), 1, 0, 0, 0, 0);
		add_row(pack8(0, 0, 5, 0, 1, -3, 1, 7), 1, 64'sd1 <<< FB, 0, 0, 0);
		add_row(pack8(0, 0, 1, 1, 0, 1, 1, 2), 1, 0, 0, 1, 0);
		add_row(pack8(3, -4, 9, 2, 7, 7, 7, 7), 1, 0, 0, 1, 0);
		add_row(pack8(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN), 0);
		add_row(pack8(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN + 1, CMAX, CMAX), 0);
		add_row(pack8(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX - 1), 0);
		add_row(pack8(CMIN, CMAX, CMAX, CMIN + 1, CMIN + 1, CMAX, CMAX, CMIN + 2), 0);
		add_row(pack8(0, 0, 3, 1, 0, 1, 1, 0), 0);
		add_row(pack8(-7, -3, -2, 5, 4, -9, -6, 2), 0);
		add_row(pack8('h55555, 'haaaaa, 'haaaaa, 'h55555,
			'h55555, 'h55555, 'haaaaa, 'haaaaa), 0);
		add_row(pack8(CMAX, 0, CMIN, 1, 0, CMAX, 1, CMIN), 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) begin
			row = dir_table[i];
			send_word(row.word, gap_len());
			pending_cross = {pending_cross, row.typed ? row.res : predict_cross(row.word)};
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 600) begin
				s_tvalid <= 1'b0;
				wait (pending_cross.size() == 0);
				@(posedge clk);
			end
			if (i == 300)
				stall_req = 1'b1;
			w = random_word();
			send_word(w, (i >= 400 && i < 500) ? 0 : gap_len());
			pending_cross = {pending_cross, predict_cross(w)};
		end
		s_tvalid <= 1'b0;

		wait (pending_cross.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("%0d line pairs sent, %0d results checked", n_sent, n_recv);
		$display("%0d parallel, %0d saturated", n_par, n_sat);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

	// receiver backpressure
	initial begin
		int hold;
		int run;
		@(posedge arst_n);
		forever begin
			if (stall_req) begin
				stall_req = 1'b0;
				m_tready <= 1'b0;
				hold = 0;
				while (hold < 400) begin
					@(posedge clk);
					hold++;
				end
			end
			run = $urandom_range(0, 9) == 0 ? 150 : $urandom_range(1, 12);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			hold = gap_len();
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		cross_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_cross.size() == 0) begin
				$display("unexpected word %0d out of the block", n_recv);
				errors++;
			end else begin
				want = pending_cross.pop_front();
				if (m_tdata[OUT_WIDTH-1:0] !== want.cx)
					report_mismatch("cross_x", m_tdata[OUT_WIDTH-1:0], want.cx);
				if (m_tdata[2*OUT_WIDTH-1:OUT_WIDTH] !== want.cy)
					report_mismatch("cross_y", m_tdata[2*OUT_WIDTH-1:OUT_WIDTH], want.cy);
				if (m_tuser[0] !== want.par)
					report_mismatch("parallel", OUT_WIDTH'(m_tuser[0]),
						OUT_WIDTH'(want.par));
				if (m_tuser[1] !== want.sat)
					report_mismatch("saturated", OUT_WIDTH'(m_tuser[1]),
						OUT_WIDTH'(want.sat));
				n_par += int'(want.par);
				n_sat += int'(want.sat);
			end
			n_recv++;
		end
	end

endmodule
